// ===== src/mrpf_pkg.sv =====
// Shared types, constants and codes for the MQTT receive packet framer.
package mrpf_pkg;

	// Store size and header limits
	localparam int STORE_BYTES       = 512;
	localparam int MAX_LENGTH_GROUPS = 4;

	// Widths
	localparam int CNT_W   = $clog2(STORE_BYTES);
	localparam int GRP_W   = 3;
	localparam int ACC_W   = 28;
	localparam int TLEN_W  = 16;
	localparam int LEN_W   = 9;

	localparam logic [CNT_W-1:0] STORE_LAST = CNT_W'(STORE_BYTES - 1);
	localparam logic [GRP_W-1:0] GROUP_MAX  = GRP_W'(MAX_LENGTH_GROUPS);

	// Packet type nibbles
	localparam logic [3:0] PKT_RESERVED_LO = 4'h0;
	localparam logic [3:0] PKT_RESERVED_HI = 4'hF;
	localparam logic [3:0] PKT_PUBLISH     = 4'h3;

	// QoS codes
	localparam logic [1:0] QOS_0       = 2'd0;
	localparam logic [1:0] QOS_1       = 2'd1;
	localparam logic [1:0] QOS_2       = 2'd2;
	localparam logic [1:0] QOS_INVALID = 2'd3;

	// Byte roles
	localparam logic [2:0] ROLE_DISCARD = 3'd0;
	localparam logic [2:0] ROLE_HEADER  = 3'd1;
	localparam logic [2:0] ROLE_LENID   = 3'd2;
	localparam logic [2:0] ROLE_TOPIC   = 3'd3;
	localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
	localparam logic [2:0] ROLE_OTHER   = 3'd5;

	// Packet status
	localparam logic [2:0] ST_BUSY      = 3'd0;
	localparam logic [2:0] ST_SKIP      = 3'd1;
	localparam logic [2:0] ST_PUB       = 3'd2;
	localparam logic [2:0] ST_OTHER     = 3'd3;
	localparam logic [2:0] ST_MALFORMED = 3'd4;
	localparam logic [2:0] ST_HDR_ERR   = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       resync;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic [2:0]       byte_role;
		logic [2:0]       status;
		logic             aborted_previous;
		logic [LEN_W-1:0] topic_bytes;
		logic [LEN_W-1:0] payload_bytes;
		logic [1:0]       qos_level;
		logic             packet_last;
	} out_item_t;

	// Framer state carried between bytes
	typedef struct packed {
		logic [CNT_W-1:0]  byte_count;
		logic [7:0]        first_byte;
		logic [GRP_W-1:0]  length_groups_seen;
		logic [ACC_W-1:0]  remaining_accum;
		logic              header_known;
		logic [CNT_W-1:0]  expected_total;
		logic [TLEN_W-1:0] topic_len_reg;
	} framer_state_t;

endpackage

// ===== src/mrpf_step.sv =====
// Per-byte framing logic: next framer state and the result for one byte.
module mrpf_step (
	input  mrpf_pkg::framer_state_t cur,
	input  mrpf_pkg::in_item_t      item,
	output mrpf_pkg::framer_state_t nxt,
	output mrpf_pkg::out_item_t     res
);

	mrpf_pkg::framer_state_t s;
	logic [7:0]                    b;
	logic [mrpf_pkg::CNT_W-1:0]    cnt;
	logic [mrpf_pkg::CNT_W-1:0]    room;
	logic [mrpf_pkg::CNT_W-1:0]    pos;
	logic [mrpf_pkg::CNT_W-1:0]    body;
	logic [mrpf_pkg::CNT_W-1:0]    rest;
	logic [mrpf_pkg::ACC_W-1:0]    acc;
	logic [4:0]                    shamt;
	logic [mrpf_pkg::TLEN_W:0]     tl_x;
	logic [mrpf_pkg::TLEN_W:0]     pos_x;
	logic [mrpf_pkg::TLEN_W:0]     body_x;
	logic [1:0]                    qos;
	logic                          done;
	logic [2:0]                    status;

	// Resync clears any partial packet before this byte is handled
	always_comb begin
		s = item.resync ? '0 : cur;
	end

	always_comb begin
		b      = item.rx_byte;
		nxt    = s;
		res    = '0;
		res.data_byte        = b;
		res.aborted_previous = item.resync && (cur.byte_count != '0);
		status = mrpf_pkg::ST_BUSY;
		done   = 1'b0;
		cnt    = s.byte_count + 1'b1;
		room   = '0;
		acc    = s.remaining_accum;
		shamt  = '0;
		pos    = '0;
		pos_x  = '0;
		body   = '0;
		body_x = '0;
		rest   = '0;
		tl_x   = '0;
		qos    = s.first_byte[2:1];

		if (s.byte_count == '0 && (b[7:4] == mrpf_pkg::PKT_RESERVED_LO ||
				b[7:4] == mrpf_pkg::PKT_RESERVED_HI)) begin
			// Idle byte with a reserved type is skipped
			res.status = mrpf_pkg::ST_SKIP;
		end else if (s.byte_count >= mrpf_pkg::STORE_LAST) begin
			// No room left: drop the packet
			nxt             = '0;
			res.status      = mrpf_pkg::ST_FULL;
			res.packet_last = 1'b1;
		end else begin
			nxt.byte_count = cnt;
			if (cnt == mrpf_pkg::CNT_W'(1)) begin
				nxt.first_byte = b;
				res.byte_role  = mrpf_pkg::ROLE_HEADER;
			end else if (!s.header_known) begin
				// Remaining-length bytes, least significant group first
				res.byte_role = mrpf_pkg::ROLE_HEADER;
				if (s.length_groups_seen >= mrpf_pkg::GROUP_MAX) begin
					status = mrpf_pkg::ST_HDR_ERR;
				end else begin
					shamt = 5'(s.length_groups_seen[1:0]) * 5'd7;
					acc   = s.remaining_accum +
						(mrpf_pkg::ACC_W'(b[6:0]) << shamt);
					nxt.remaining_accum    = acc;
					nxt.length_groups_seen = s.length_groups_seen + 1'b1;
					if (!b[7]) begin
						room = (mrpf_pkg::STORE_LAST > cnt) ?
							mrpf_pkg::STORE_LAST - cnt : '0;
						if (acc > mrpf_pkg::ACC_W'(room)) begin
							status = mrpf_pkg::ST_HDR_ERR;
						end else begin
							nxt.expected_total = cnt + acc[mrpf_pkg::CNT_W-1:0];
							nxt.header_known   = 1'b1;
							done               = (acc == '0);
						end
					end else if (nxt.length_groups_seen >= mrpf_pkg::GROUP_MAX) begin
						status = mrpf_pkg::ST_HDR_ERR;
					end
				end
			end else begin
				// Body bytes
				if (s.first_byte[7:4] == mrpf_pkg::PKT_PUBLISH) begin
					pos   = cnt - mrpf_pkg::CNT_W'(2) -
						mrpf_pkg::CNT_W'(s.length_groups_seen);
					pos_x = (mrpf_pkg::TLEN_W+1)'(pos);
					tl_x  = (mrpf_pkg::TLEN_W+1)'(s.topic_len_reg);
					if (pos == '0) begin
						nxt.topic_len_reg = {b, 8'h00};
						res.byte_role     = mrpf_pkg::ROLE_LENID;
					end else if (pos == mrpf_pkg::CNT_W'(1)) begin
						nxt.topic_len_reg = {s.topic_len_reg[15:8], b};
						res.byte_role     = mrpf_pkg::ROLE_LENID;
					end else if (pos_x < tl_x + 17'd2) begin
						res.byte_role = mrpf_pkg::ROLE_TOPIC;
					end else if ((qos == mrpf_pkg::QOS_1 || qos == mrpf_pkg::QOS_2) &&
							pos_x < tl_x + 17'd4) begin
						res.byte_role = mrpf_pkg::ROLE_LENID;
					end else begin
						res.byte_role = mrpf_pkg::ROLE_PAYLOAD;
					end
				end else begin
					res.byte_role = mrpf_pkg::ROLE_OTHER;
				end
				done = (cnt >= s.expected_total);
			end

			// Final status of a completed packet
			if (done) begin
				if (nxt.first_byte[7:4] != mrpf_pkg::PKT_PUBLISH) begin
					status = mrpf_pkg::ST_OTHER;
				end else begin
					body   = nxt.remaining_accum[mrpf_pkg::CNT_W-1:0];
					body_x = (mrpf_pkg::TLEN_W+1)'(body);
					tl_x   = (mrpf_pkg::TLEN_W+1)'(nxt.topic_len_reg);
					if (body < mrpf_pkg::CNT_W'(2) || tl_x + 17'd2 > body_x ||
							qos == mrpf_pkg::QOS_INVALID) begin
						status = mrpf_pkg::ST_MALFORMED;
					end else begin
						rest = body - mrpf_pkg::CNT_W'(2) -
							nxt.topic_len_reg[mrpf_pkg::CNT_W-1:0];
						if (qos != mrpf_pkg::QOS_0 && rest < mrpf_pkg::CNT_W'(2)) begin
							status = mrpf_pkg::ST_MALFORMED;
						end else begin
							if (qos != mrpf_pkg::QOS_0)
								rest = rest - mrpf_pkg::CNT_W'(2);
							status            = mrpf_pkg::ST_PUB;
							res.topic_bytes   =
								mrpf_pkg::LEN_W'(nxt.topic_len_reg[mrpf_pkg::CNT_W-1:0]);
							res.payload_bytes = mrpf_pkg::LEN_W'(rest);
							res.qos_level     = qos;
						end
					end
				end
			end

			res.status = status;
			if (status != mrpf_pkg::ST_BUSY) begin
				res.packet_last = 1'b1;
				nxt             = '0;
			end
		end
	end

endmodule

// ===== src/mqtt_rx_packet_framer.sv =====
// Top level of the MQTT receive packet framer: handshake, state and result registers.
//
//  channel  | valid         | ready         | payload
//  input    | item_valid    | item_ready    | item   (rx_byte, resync)
//  output   | result_valid  | result_ready  | result (byte echo, role, status, lengths)
//
// One byte per cycle while results are taken; a byte enters the input register when
// accepted and moves into the result register once that register is empty or being read.
// Framing state is updated in the same cycle the byte moves into the result register.
// arst_n clears the framing state and both valid flags.
// A stalled result holds the input register; the input side still accepts while the
// input register is empty or its byte moves on to the result register.
module mqtt_rx_packet_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  mrpf_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output mrpf_pkg::out_item_t result
);

	logic                    valid_s1;
	mrpf_pkg::in_item_t      item_s1;
	mrpf_pkg::framer_state_t state_q;
	mrpf_pkg::framer_state_t state_nxt;
	mrpf_pkg::out_item_t     res_nxt;
	mrpf_pkg::out_item_t     result_q;
	logic                    result_valid_q;
	logic                    advance;

	// Handshake
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	// Per-byte framing logic
	mrpf_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= res_nxt;
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Checks
	a_total_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.header_known |-> state_q.expected_total > state_q.byte_count)
		else $error("expected total not ahead of byte count");

	a_groups_seen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.header_known |-> state_q.length_groups_seen != '0)
		else $error("header known without length groups");

	a_skip_form: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.status == mrpf_pkg::ST_SKIP) |->
		(result_q.byte_role == mrpf_pkg::ROLE_DISCARD && !result_q.packet_last))
		else $error("skipped byte with role or end mark");

	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_q.packet_last) |->
		(result_q.status != mrpf_pkg::ST_BUSY && result_q.status != mrpf_pkg::ST_SKIP))
		else $error("packet end without final status");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nxt.packet_last) |=> state_q.byte_count == '0)
		else $error("framer not idle after packet end");

endmodule

// ===== tb/sv/mqtt_rx_packet_framer_tb.sv =====
// Self-checking testbench for the MQTT receive packet framer.
module mqtt_rx_packet_framer_tb;
	import mrpf_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RX_HOLD_CYCLES = 150;
	localparam int FRAMED_TARGET  = 1050;

	logic      clk          = 1'b0;
	logic      arst_n       = 1'b0;
	logic      item_valid   = 1'b0;
	logic      item_ready;
	in_item_t  item         = '0;
	logic      result_valid;
	logic      result_ready = 1'b0;
	out_item_t result;

	mqtt_rx_packet_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #5 clk = ~clk;

	// Framer state as predicted, plus the tagged bytes still owed by the block
	framer_state_t framing;
	out_item_t     tagged_due[$];

	int  mismatches    = 0;
	int  tags_checked  = 0;
	int  bytes_framed  = 0;
	int  aborts_seen   = 0;
	int  status_seen[7];
	bit  tx_gaps_on    = 1'b1;
	bit  rx_gaps_on    = 1'b1;
	bit  rx_hold_req   = 1'b0;
	int  rx_stall_left = 0;
	int  stall_cycles  = 0;

	initial framing = '0;

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap(input bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	// Tag one byte and advance the predicted framing state
	function automatic out_item_t frame_byte(input in_item_t it);
		out_item_t   r;
		int unsigned cnt, room, pos, tl, body, rest;
		logic [1:0]  qos;
		logic        done;
		r           = '0;
		r.data_byte = it.rx_byte;
		r.byte_role = ROLE_DISCARD;
		r.status    = ST_BUSY;
		done        = 1'b0;

		if (it.resync) begin
			if (framing.byte_count != 0)
				r.aborted_previous = 1'b1;
			framing = '0;
		end

		// Reserved type nibbles are dropped while hunting for a start
		if (framing.byte_count == 0 &&
		    (it.rx_byte[7:4] == PKT_RESERVED_LO || it.rx_byte[7:4] == PKT_RESERVED_HI)) begin
			r.status = ST_SKIP;
			return r;
		end

		if (framing.byte_count >= STORE_LAST) begin
			framing       = '0;
			r.status      = ST_FULL;
			r.packet_last = 1'b1;
			return r;
		end

		framing.byte_count = framing.byte_count + 1'b1;
		cnt = framing.byte_count;

		if (cnt == 1) begin
			framing.first_byte = it.rx_byte;
			r.byte_role        = ROLE_HEADER;
		end else if (!framing.header_known) begin
			// Remaining length, least significant group first
			r.byte_role = ROLE_HEADER;
			if (framing.length_groups_seen >= GROUP_MAX) begin
				r.status = ST_HDR_ERR;
			end else begin
				framing.remaining_accum = framing.remaining_accum +
					(ACC_W'(it.rx_byte[6:0]) << (7 * framing.length_groups_seen));
				framing.length_groups_seen = framing.length_groups_seen + 1'b1;
				if (!it.rx_byte[7]) begin
					room = (STORE_BYTES - 1 > cnt) ? STORE_BYTES - 1 - cnt : 0;
					if (framing.remaining_accum > room) begin
						r.status = ST_HDR_ERR;
					end else begin
						framing.expected_total = CNT_W'(cnt + framing.remaining_accum);
						framing.header_known   = 1'b1;
						if (cnt >= framing.expected_total)
							done = 1'b1;
					end
				end else if (framing.length_groups_seen >= GROUP_MAX) begin
					r.status = ST_HDR_ERR;
				end
			end
		end else begin
			// Body: PUBLISH layout is topic length, topic, optional id, payload
			if (framing.first_byte[7:4] == PKT_PUBLISH) begin
				pos = cnt - 2 - framing.length_groups_seen;
				tl  = framing.topic_len_reg;
				qos = framing.first_byte[2:1];
				if (pos == 0) begin
					framing.topic_len_reg = {it.rx_byte, 8'h00};
					r.byte_role = ROLE_LENID;
				end else if (pos == 1) begin
					framing.topic_len_reg[7:0] = it.rx_byte;
					r.byte_role = ROLE_LENID;
				end else if (pos < 2 + tl) begin
					r.byte_role = ROLE_TOPIC;
				end else if ((qos == QOS_1 || qos == QOS_2) && pos < 4 + tl) begin
					r.byte_role = ROLE_LENID;
				end else begin
					r.byte_role = ROLE_PAYLOAD;
				end
			end else begin
				r.byte_role = ROLE_OTHER;
			end
			if (cnt >= framing.expected_total)
				done = 1'b1;
		end

		// Final status of a complete packet
		if (done) begin
			if (framing.first_byte[7:4] != PKT_PUBLISH) begin
				r.status = ST_OTHER;
			end else begin
				body = framing.remaining_accum;
				tl   = framing.topic_len_reg;
				qos  = framing.first_byte[2:1];
				if (body < 2 || tl > body - 2 || qos == QOS_INVALID) begin
					r.status = ST_MALFORMED;
				end else begin
					rest = body - 2 - tl;
					if (qos != QOS_0 && rest < 2) begin
						r.status = ST_MALFORMED;
					end else begin
						if (qos != QOS_0)
							rest = rest - 2;
						r.status        = ST_PUB;
						r.topic_bytes   = LEN_W'(tl);
						r.payload_bytes = LEN_W'(rest);
						r.qos_level     = qos;
					end
				end
			end
		end

		if (r.status != ST_BUSY) begin
			r.packet_last = 1'b1;
			framing       = '0;
		end
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
	                                    input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Compare one tagged byte with the oldest prediction
	task automatic check_tag(input out_item_t got);
		out_item_t want;
		if (tagged_due.size() == 0) begin
			$error("result with nothing expected: data_byte %02h", got.data_byte);
			mismatches++;
			return;
		end
		want = tagged_due.pop_front();
		tags_checked++;
		if (got.status <= ST_FULL)
			status_seen[got.status]++;
		if (got.aborted_previous === 1'b1)
			aborts_seen++;
		check_field("data_byte", want.data_byte, got.data_byte);
		check_field("byte_role", want.byte_role, got.byte_role);
		check_field("status", want.status, got.status);
		check_field("aborted_previous", want.aborted_previous, got.aborted_previous);
		check_field("topic_bytes", want.topic_bytes, got.topic_bytes);
		check_field("payload_bytes", want.payload_bytes, got.payload_bytes);
		check_field("qos_level", want.qos_level, got.qos_level);
		check_field("packet_last", want.packet_last, got.packet_last);
	endtask

	// Result side: check each transaction, then pick ready for the next cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_stall_left = 0;
		end else begin
			if (result_valid && result_ready)
				check_tag(result);
			if (rx_hold_req) begin
				rx_hold_req   = 1'b0;
				rx_stall_left = RX_HOLD_CYCLES;
			end
			if (rx_stall_left > 0) begin
				result_ready <= 1'b0;
				rx_stall_left--;
			end else begin
				result_ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					rx_stall_left = pick_gap(rx_gaps_on);
			end
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// Offer one byte; returns after acceptance and an optional gap
	task automatic send_byte(input logic [7:0] b, input logic rs = 1'b0);
		in_item_t  it;
		out_item_t tag;
		int        gap;
		it.rx_byte = b;
		it.resync  = rs;
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		tag = frame_byte(it);
		tagged_due.push_back(tag);
		if (tag.status != ST_SKIP)
			bytes_framed++;
		gap = pick_gap(tx_gaps_on);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Fixed header, remaining length (optional empty groups), body minus drop tail bytes
	task automatic send_frame(input logic [7:0] first, input logic [7:0] body[$], input int pad,
	                          input int drop, input logic resync_first);
		logic [7:0] frame[$];
		int         len, n;
		frame.push_back(first);
		len = body.size();
		do begin
			frame.push_back(8'(len % 128) | ((len >= 128) ? 8'h80 : 8'h00));
			len = len / 128;
		end while (len > 0);
		repeat (pad) begin
			frame[frame.size() - 1] = frame[frame.size() - 1] | 8'h80;
			frame.push_back(8'h00);
		end
		frame = {frame, body};
		n = frame.size() - drop;
		for (int i = 0; i < n; i++)
			send_byte(frame[i], (i == 0) && resync_first);
	endtask

	task automatic send_publish(input logic [1:0] qos, input int topic_len, input int payload_len,
	                            input int declared_tl, input int pad, input logic resync_first);
		logic [7:0]  body[$];
		logic [15:0] tl;
		tl = 16'(declared_tl);
		body.push_back(tl[15:8]);
		body.push_back(tl[7:0]);
		repeat (topic_len) body.push_back(8'($urandom_range(32, 126)));
		if (qos != QOS_0) begin
			body.push_back(8'($urandom));
			body.push_back(8'($urandom));
		end
		repeat (payload_len) body.push_back(8'($urandom));
		send_frame({PKT_PUBLISH, 1'($urandom), qos, 1'($urandom)}, body, pad, 0, resync_first);
	endtask

	task automatic send_control(input logic [3:0] kind, input int body_len, input int pad,
	                            input int drop, input logic resync_first);
		logic [7:0] body[$];
		repeat (body_len) body.push_back(8'($urandom));
		send_frame({kind, 4'($urandom)}, body, pad, drop, resync_first);
	endtask

	function automatic logic [3:0] pick_kind();
		logic [3:0] k;
		do k = 4'($urandom_range(1, 14)); while (k == PKT_PUBLISH);
		return k;
	endfunction

	// Body sizes: mostly small, sometimes medium, rarely large
	function automatic int pick_body_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(0, 24);
		if (r < 97)
			return $urandom_range(25, 127);
		return $urandom_range(128, 420);
	endfunction

	// Skipped idle bytes, resync with and without a pending packet, empty body
	task automatic test_skip_and_resync();
		send_byte(8'h00);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h30);
		send_byte(8'h05);
		send_byte(8'h00);
		send_byte(8'hC0, 1'b1);
		send_byte(8'h00);
	endtask

	// Too many length groups, oversize by one, longest legal length field
	task automatic test_length_limits();
		logic [7:0] no_body[$];
		send_byte(8'h30);
		repeat (4) send_byte(8'h80);
		send_byte(8'h20);
		send_byte(8'hFD);
		send_byte(8'h03);
		send_frame(8'hD0, no_body, 3, 0, 1'b0);
	endtask

	// Malformed PUBLISH: QoS 3, body too short, topic length beyond the body
	task automatic test_publish_malformed();
		send_byte(8'h36);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h30);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h3B);
		send_byte(8'h03);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h41);
	endtask

	// Receiver holds off while the sender keeps offering, so the input stalls
	task automatic test_backpressure();
		tx_gaps_on  = 1'b0;
		rx_hold_req = 1'b1;
		send_publish(QOS_1, 6, 12, 6, 0, 1'b0);
		send_control(4'h4, 2, 0, 0, 1'b0);
		send_publish(QOS_0, 3, 9, 3, 0, 1'b0);
		tx_gaps_on = 1'b1;
	endtask

	// Mostly well-formed packets with random content, plus noise and broken frames
	task automatic test_random_traffic();
		int         r, pad, tl, len;
		logic       resync_first, resync_next;
		logic [1:0] qos;
		logic [7:0] first;
		resync_next = 1'b0;
		// Largest packet the store takes, and a topic length above one byte
		send_publish(QOS_1, 5, 499, 5, 0, 1'b0);
		send_publish(QOS_0, 300, 4, 300, 0, 1'b0);
		while (bytes_framed < FRAMED_TARGET) begin
			tx_gaps_on   = ($urandom_range(0, 4) != 0);
			rx_gaps_on   = ($urandom_range(0, 4) != 0);
			resync_first = ($urandom_range(0, 19) == 0) || resync_next;
			resync_next  = 1'b0;
			pad = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
			r   = $urandom_range(0, 99);
			if (r < 45) begin
				qos = 2'($urandom_range(0, 2));
				tl  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
				send_publish(qos, tl, pick_body_len(), tl, pad, resync_first);
			end else if (r < 70) begin
				send_control(pick_kind(), pick_body_len(), pad, 0, resync_first);
			end else if (r < 80) begin
				tl = $urandom_range(0, 10);
				case ($urandom_range(0, 2))
					0: send_publish(QOS_INVALID, tl, $urandom_range(0, 8), tl, pad, resync_first);
					1: send_publish(2'($urandom_range(0, 2)), tl, $urandom_range(0, 8),
					                tl + $urandom_range(1, 70000), pad, resync_first);
					default: send_publish(QOS_1, tl, 0, tl + 1, pad, resync_first);
				endcase
			end else if (r < 87) begin
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom));
				resync_next = 1'b1;
			end else if (r < 94) begin
				send_control(pick_kind(), $urandom_range(2, 20), pad, $urandom_range(1, 2),
				             resync_first);
				resync_next = 1'b1;
			end else if ($urandom_range(0, 1) == 0) begin
				send_control(pick_kind(), $urandom_range(0, 6), $urandom_range(3, 4), 0,
				             resync_first);
				resync_next = 1'b1;
			end else begin
				len   = $urandom_range(509, 16383);
				first = ($urandom_range(0, 1) == 0) ? {PKT_PUBLISH, 4'($urandom)}
				                                    : {pick_kind(), 4'($urandom)};
				send_byte(first, resync_first);
				send_byte(8'(len % 128) | 8'h80);
				send_byte(8'(len / 128));
				resync_next = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_skip_and_resync();
		test_length_limits();
		test_publish_malformed();
		test_backpressure();
		test_random_traffic();

		item_valid <= 1'b0;
		while (tagged_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("framed %0d bytes, checked %0d tags; delivered %0d, other %0d, malformed %0d",
		         bytes_framed, tags_checked, status_seen[ST_PUB], status_seen[ST_OTHER],
		         status_seen[ST_MALFORMED]);
		$display("header errors %0d, skipped %0d, aborted by resync %0d, mismatches %0d",
		         status_seen[ST_HDR_ERR], status_seen[ST_SKIP], aborts_seen, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
